>>> rtl/core/deq_pkg.sv
package deq_pkg;

   typedef enum logic [2:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_PEEK       = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD       = 2'd0,
      OP_SHIFT_UP   = 2'd1,
      OP_SHIFT_DOWN = 2'd2,
      OP_LOAD       = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type a_op;
      cell_op_type b_op;
   } cell_ctrl_type;

endpackage

>>> rtl/core/deq_cell.sv
module deq_cell #(
   parameter int INDEX       = 0,
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 7
) (
   input  logic                   clock,
   input  deq_pkg::cell_ctrl_type ctrl,
   input  logic [COUNT_WIDTH-1:0] count,
   input  logic [VALUE_WIDTH-1:0] value,
   input  logic [VALUE_WIDTH-1:0] a_prev,
   input  logic [VALUE_WIDTH-1:0] a_next,
   input  logic [VALUE_WIDTH-1:0] b_prev,
   input  logic [VALUE_WIDTH-1:0] b_next,
   output logic [VALUE_WIDTH-1:0] a_ff,
   output logic [VALUE_WIDTH-1:0] b_ff,
   output logic [VALUE_WIDTH-1:0] a_in,
   output logic [VALUE_WIDTH-1:0] b_in
);

   logic at_count;

   assign at_count = (count == COUNT_WIDTH'(INDEX));

   always_comb begin
      case (ctrl.a_op)
         deq_pkg::OP_SHIFT_UP:   a_in = a_prev;
         deq_pkg::OP_SHIFT_DOWN: a_in = a_next;
         deq_pkg::OP_LOAD:       a_in = at_count ? value : a_ff;
         default:                a_in = a_ff;
      endcase
   end

   always_comb begin
      case (ctrl.b_op)
         deq_pkg::OP_SHIFT_UP:   b_in = b_prev;
         deq_pkg::OP_SHIFT_DOWN: b_in = b_next;
         deq_pkg::OP_LOAD:       b_in = at_count ? value : b_ff;
         default:                b_in = b_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

endmodule

>>> rtl/core/deq_ctrl.sv
module deq_ctrl #(
   parameter int DEPTH       = 64,
   parameter int COUNT_WIDTH = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [2:0]             action,
   output deq_pkg::cell_ctrl_type ctrl,
   output logic [COUNT_WIDTH-1:0] count_ff,
   output logic [COUNT_WIDTH-1:0] count_in,
   output deq_pkg::status_type    status
);

   logic full;
   logic empty;

   assign full  = (count_ff == COUNT_WIDTH'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      ctrl.a_op = deq_pkg::OP_HOLD;
      ctrl.b_op = deq_pkg::OP_HOLD;
      count_in  = count_ff;
      status    = deq_pkg::ST_OK;
      if (accept) begin
         unique case (action)
            deq_pkg::ACT_PUSH_FRONT: begin
               if (full) begin
                  status = deq_pkg::ST_FULL;
               end else begin
                  ctrl.a_op = deq_pkg::OP_SHIFT_UP;
                  ctrl.b_op = deq_pkg::OP_LOAD;
                  count_in  = count_ff + COUNT_WIDTH'(1);
               end
            end
            deq_pkg::ACT_PUSH_BACK: begin
               if (full) begin
                  status = deq_pkg::ST_FULL;
               end else begin
                  ctrl.a_op = deq_pkg::OP_LOAD;
                  ctrl.b_op = deq_pkg::OP_SHIFT_UP;
                  count_in  = count_ff + COUNT_WIDTH'(1);
               end
            end
            deq_pkg::ACT_POP_FRONT: begin
               if (empty) begin
                  status = deq_pkg::ST_EMPTY;
               end else begin
                  ctrl.a_op = deq_pkg::OP_SHIFT_DOWN;
                  count_in  = count_ff - COUNT_WIDTH'(1);
               end
            end
            deq_pkg::ACT_POP_BACK: begin
               if (empty) begin
                  status = deq_pkg::ST_EMPTY;
               end else begin
                  ctrl.b_op = deq_pkg::OP_SHIFT_DOWN;
                  count_in  = count_ff - COUNT_WIDTH'(1);
               end
            end
            default: begin
               status = deq_pkg::ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/core/double_ended_queue_top.sv
// Double-ended queue of signed VALUE_WIDTH-bit words with room for DEPTH entries. Each request
// word carries one action (push front, push back, pop front, pop back, peek; unused codes act
// as peek) and yields exactly one response word with the front and back entries, the count
// after the action and a status (ok, pop on empty, push dropped because full). An empty queue
// reports the most negative value for front and back. One request is taken per clock; its
// response is registered and appears the cycle after acceptance. While that response waits
// unaccepted the request side is held off, and a new request is taken in the cycle that the
// response leaves. The entries sit in a row of DEPTH cells holding two copies, one
// aligned to the front and one to the back, so both ends are read at cell 0 and every action
// is a one-step shift or a local load; storage is 2 x DEPTH x VALUE_WIDTH flops. No clearing
// pass is needed after reset.
module double_ended_queue_top #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32,
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1),
   localparam int REQ_TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8,
   localparam int RSP_BITS    = 2 * VALUE_WIDTH + COUNT_WIDTH + 2,
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // value
   input  logic [2:0]             req_tuser,   // action
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // front_value, back_value, count, status
);

   localparam logic [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

   logic                   accept;
   logic [VALUE_WIDTH-1:0] value;
   deq_pkg::cell_ctrl_type ctrl;
   logic [COUNT_WIDTH-1:0] count_q;
   logic [COUNT_WIDTH-1:0] count_next;
   deq_pkg::status_type    status;

   logic [VALUE_WIDTH-1:0] cell_a_ff [DEPTH];
   logic [VALUE_WIDTH-1:0] cell_b_ff [DEPTH];
   logic [VALUE_WIDTH-1:0] cell_a_in [DEPTH];
   logic [VALUE_WIDTH-1:0] cell_b_in [DEPTH];

   logic                   rsp_valid_ff;
   logic [VALUE_WIDTH-1:0] front_ff;
   logic [VALUE_WIDTH-1:0] back_ff;
   logic [COUNT_WIDTH-1:0] count_out_ff;
   logic [1:0]             status_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign value      = req_tdata[VALUE_WIDTH-1:0];

   deq_ctrl #(
      .DEPTH       (DEPTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .action   (req_tuser),
      .ctrl     (ctrl),
      .count_ff (count_q),
      .count_in (count_next),
      .status   (status)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] a_prev;
      logic [VALUE_WIDTH-1:0] a_next;
      logic [VALUE_WIDTH-1:0] b_prev;
      logic [VALUE_WIDTH-1:0] b_next;

      if (i == 0) begin : g_first
         assign a_prev = value;
         assign b_prev = value;
      end else begin : g_mid
         assign a_prev = cell_a_ff[i-1];
         assign b_prev = cell_b_ff[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign a_next = cell_a_ff[i];
         assign b_next = cell_b_ff[i];
      end else begin : g_inner
         assign a_next = cell_a_ff[i+1];
         assign b_next = cell_b_ff[i+1];
      end

      deq_cell #(
         .INDEX       (i),
         .VALUE_WIDTH (VALUE_WIDTH),
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_cell (
         .clock  (clock),
         .ctrl   (ctrl),
         .count  (count_q),
         .value  (value),
         .a_prev (a_prev),
         .a_next (a_next),
         .b_prev (b_prev),
         .b_next (b_next),
         .a_ff   (cell_a_ff[i]),
         .b_ff   (cell_b_ff[i]),
         .a_in   (cell_a_in[i]),
         .b_in   (cell_b_in[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_ff     <= (count_next == '0) ? VALUE_MIN : cell_a_in[0];
         back_ff      <= (count_next == '0) ? VALUE_MIN : cell_b_in[0];
         count_out_ff <= count_next;
         status_ff    <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({status_ff, count_out_ff, back_ff, front_ff});

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_q <= COUNT_WIDTH'(DEPTH))
      else $error("entry count beyond capacity");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_q))
      else $error("entry count moved without a request");

   a_drop_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && status != deq_pkg::ST_OK) |=> $stable(count_q))
      else $error("rejected action changed the queue");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid && count_out_ff == count_q)
      else $error("response missing or count mismatch");

   a_empty_min: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && count_out_ff == '0) |-> (front_ff == VALUE_MIN && back_ff == VALUE_MIN))
      else $error("empty queue must report the most negative value");

endmodule
